// ===== design/nls_pkg.sv =====
// Shared types, constants, character-class helpers and step functions for the numeric literal scanner.
package nls_pkg;

  localparam int MAX_LEN = 255;
  localparam int LEN_LIMIT = (MAX_LEN < 255) ? MAX_LEN : 255;
  localparam int CHAR_W = 8;
  localparam int LEN_W = 8;
  localparam int STATUS_W = 2;
  localparam int MODE_W = 2;
  localparam int MODE_SLASH_BIT = 0;
  localparam int MODE_IMAG_BIT = 1;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_BEGIN    = 4'd1,
    PH_AFTSIGN  = 4'd2,
    PH_ZERO     = 4'd3,
    PH_HEX      = 4'd4,
    PH_BIN      = 4'd5,
    PH_OCT      = 4'd6,
    PH_DECINT   = 4'd7,
    PH_FRAC     = 4'd8,
    PH_POINT    = 4'd9,
    PH_EXP      = 4'd10,
    PH_EXPSIGN  = 4'd11,
    PH_EXPDIG   = 4'd12,
    PH_SUFFIX   = 4'd13
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ILLEGAL  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  // What one character does to the scan before the suffix is resolved.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_TAKE,
    ACT_ILLEGAL,
    ACT_BODY_END,
    ACT_FINISH
  } act_t;

  typedef struct packed {
    act_t   act;
    phase_t nxt;
  } step_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    return (c == "+") || (c == "-");
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(input logic [CHAR_W-1:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_exp(input logic [CHAR_W-1:0] c);
    return (c == "e") || (c == "E");
  endfunction

  // Integer part of a decimal literal: digits, fraction slash, point or exponent.
  function automatic step_t dec_int_step(input logic [CHAR_W-1:0] c, input logic slash);
    step_t s;
    s.act = ACT_TAKE;
    s.nxt = PH_DECINT;
    if (is_digit(c)) begin
      s.nxt = PH_DECINT;
    end else if ((c == "/") && slash) begin
      s.nxt = PH_FRAC;
    end else if (c == ".") begin
      s.nxt = PH_POINT;
    end else if (is_exp(c)) begin
      s.nxt = PH_EXP;
    end else begin
      s.act = ACT_BODY_END;
    end
    return s;
  endfunction

  // After a leading sign, or at the start when no sign came.
  function automatic step_t after_sign_step(input logic [CHAR_W-1:0] c, input logic slash);
    step_t s;
    if (is_sign(c)) begin
      s.act = ACT_ILLEGAL;
      s.nxt = PH_IDLE;
    end else if (c == "0") begin
      s.act = ACT_TAKE;
      s.nxt = PH_ZERO;
    end else begin
      s = dec_int_step(c, slash);
    end
    return s;
  endfunction

endpackage

// ===== design/numeric_literal_scanner_core.sv =====
// Top level of the numeric literal scanner: input register, phase step and result register.
//
// Usage: characters of a string arrive one per item on the in_ channel
// (in_char_in, in_start_req, in_mode_flags). An item with in_start_req high
// begins a new scan and latches in_mode_flags: bit 0 allows slash fractions,
// bit 1 allows an i suffix. Characters that arrive while no scan is open are
// dropped without a result. When the literal ends, at its terminator, on a
// doubled sign, or when it grows beyond the length limit, one item appears on
// the out_ channel with out_status (0 valid, 1 illegal, 2 too long) and
// out_length (zero unless the status is valid).
// A result is computed from the character in the input register and held in the
// result register. Throughput: one character per cycle while no result stalls,
// set by the single phase update between the input register and the result
// register. Reset (rst_n low, synchronous) empties both registers and returns the
// scan to idle. When the receiver stalls with a result pending, the character in
// the input register waits, and in_ready drops once that register is full.
module numeric_literal_scanner_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nls_pkg::CHAR_W-1:0]     in_char_in,
  input  logic                           in_start_req,
  input  logic [nls_pkg::MODE_W-1:0]     in_mode_flags,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nls_pkg::STATUS_W-1:0]   out_status,
  output logic [nls_pkg::LEN_W-1:0]      out_length
);

  // Input register: one character waiting for the phase step.
  logic                         in_v_r;
  logic [nls_pkg::CHAR_W-1:0]   char_r;
  logic                         start_r;
  logic [nls_pkg::MODE_W-1:0]   flags_r;

  // Scan state.
  nls_pkg::phase_t              phase_r, phase_nxt;
  logic [nls_pkg::LEN_W-1:0]    count_r, count_nxt;
  logic [nls_pkg::MODE_W-1:0]   mode_r, mode_nxt;

  // Result register.
  logic                         out_v_r;
  nls_pkg::status_t             status_r, status_nxt;
  logic [nls_pkg::LEN_W-1:0]    length_r, length_nxt;
  logic                         emit;

  logic                         fire;
  logic                         out_free;

  // The step runs only when the result register can take whatever it makes.
  assign out_free = !out_v_r || out_ready;
  assign fire     = in_v_r && out_free;
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      char_r  <= in_char_in;
      start_r <= in_start_req;
      flags_r <= in_mode_flags;
    end
  end

  // Phase step for the character in the input register.
  always_comb begin
    nls_pkg::phase_t                   ph;
    logic [nls_pkg::LEN_W-1:0]         cnt;
    logic [nls_pkg::MODE_W-1:0]        md;
    logic                              slash;
    logic                              imag;
    logic                              bad_term;
    logic [nls_pkg::LEN_W:0]           cnt_inc;
    nls_pkg::step_t                    s;

    // A start resets the scan before this character is looked at.
    ph    = start_r ? nls_pkg::PH_BEGIN : phase_r;
    cnt   = start_r ? '0 : count_r;
    md    = start_r ? flags_r : mode_r;
    slash = md[nls_pkg::MODE_SLASH_BIT];
    imag  = md[nls_pkg::MODE_IMAG_BIT];

    s.act = nls_pkg::ACT_NONE;
    s.nxt = nls_pkg::PH_IDLE;
    case (ph)
      nls_pkg::PH_BEGIN: begin
        if (nls_pkg::is_sign(char_r)) begin
          s.act = nls_pkg::ACT_TAKE;
          s.nxt = nls_pkg::PH_AFTSIGN;
        end else begin
          s = nls_pkg::after_sign_step(char_r, slash);
        end
      end
      nls_pkg::PH_AFTSIGN: s = nls_pkg::after_sign_step(char_r, slash);
      nls_pkg::PH_ZERO: begin
        if ((char_r == "x") || (char_r == "X")) begin
          s.act = nls_pkg::ACT_TAKE;
          s.nxt = nls_pkg::PH_HEX;
        end else if ((char_r == "b") || (char_r == "B")) begin
          s.act = nls_pkg::ACT_TAKE;
          s.nxt = nls_pkg::PH_BIN;
        end else if (nls_pkg::is_digit(char_r)) begin
          // A zero followed by 8 or 9 ends the body at that digit.
          s.act = (char_r <= "7") ? nls_pkg::ACT_TAKE : nls_pkg::ACT_BODY_END;
          s.nxt = nls_pkg::PH_OCT;
        end else begin
          s = nls_pkg::dec_int_step(char_r, slash);
        end
      end
      nls_pkg::PH_HEX: begin
        s.act = nls_pkg::is_hex(char_r) ? nls_pkg::ACT_TAKE : nls_pkg::ACT_BODY_END;
        s.nxt = nls_pkg::PH_HEX;
      end
      nls_pkg::PH_BIN: begin
        s.act = ((char_r == "0") || (char_r == "1")) ? nls_pkg::ACT_TAKE
                                                     : nls_pkg::ACT_BODY_END;
        s.nxt = nls_pkg::PH_BIN;
      end
      nls_pkg::PH_OCT: begin
        s.act = ((char_r >= "0") && (char_r <= "7")) ? nls_pkg::ACT_TAKE
                                                     : nls_pkg::ACT_BODY_END;
        s.nxt = nls_pkg::PH_OCT;
      end
      nls_pkg::PH_DECINT: s = nls_pkg::dec_int_step(char_r, slash);
      nls_pkg::PH_FRAC: begin
        s.act = nls_pkg::is_digit(char_r) ? nls_pkg::ACT_TAKE : nls_pkg::ACT_BODY_END;
        s.nxt = nls_pkg::PH_FRAC;
      end
      nls_pkg::PH_POINT: begin
        s.act = nls_pkg::ACT_TAKE;
        if (nls_pkg::is_digit(char_r)) begin
          s.nxt = nls_pkg::PH_POINT;
        end else if (nls_pkg::is_exp(char_r)) begin
          s.nxt = nls_pkg::PH_EXP;
        end else begin
          s.act = nls_pkg::ACT_BODY_END;
        end
      end
      nls_pkg::PH_EXP: begin
        s.act = nls_pkg::ACT_TAKE;
        if (nls_pkg::is_sign(char_r)) begin
          s.nxt = nls_pkg::PH_EXPSIGN;
        end else if (nls_pkg::is_digit(char_r)) begin
          s.nxt = nls_pkg::PH_EXPDIG;
        end else begin
          s.act = nls_pkg::ACT_BODY_END;
        end
      end
      nls_pkg::PH_EXPSIGN: begin
        s.act = nls_pkg::ACT_TAKE;
        s.nxt = nls_pkg::PH_EXPDIG;
        if (nls_pkg::is_sign(char_r)) begin
          s.act = nls_pkg::ACT_ILLEGAL;
        end else if (!nls_pkg::is_digit(char_r)) begin
          s.act = nls_pkg::ACT_BODY_END;
        end
      end
      nls_pkg::PH_EXPDIG: begin
        s.act = nls_pkg::is_digit(char_r) ? nls_pkg::ACT_TAKE : nls_pkg::ACT_BODY_END;
        s.nxt = nls_pkg::PH_EXPDIG;
      end
      nls_pkg::PH_SUFFIX: s.act = nls_pkg::ACT_FINISH;
      default: s.act = nls_pkg::ACT_NONE;
    endcase

    // The end of the body takes an i suffix when allowed, else it terminates.
    if (s.act == nls_pkg::ACT_BODY_END) begin
      if (((char_r == "i") || (char_r == "I")) && imag) begin
        s.act = nls_pkg::ACT_TAKE;
        s.nxt = nls_pkg::PH_SUFFIX;
      end else begin
        s.act = nls_pkg::ACT_FINISH;
      end
    end

    bad_term = (char_r == ".") || nls_pkg::is_digit(char_r) ||
               nls_pkg::is_letter(char_r) || ((char_r == "/") && slash);
    cnt_inc  = {1'b0, cnt} + {{nls_pkg::LEN_W{1'b0}}, 1'b1};

    phase_nxt  = nls_pkg::PH_IDLE;
    count_nxt  = cnt;
    mode_nxt   = md;
    emit       = 1'b0;
    status_nxt = nls_pkg::ST_OK;
    length_nxt = '0;
    case (s.act)
      nls_pkg::ACT_TAKE: begin
        if (cnt_inc > (nls_pkg::LEN_W + 1)'(nls_pkg::LEN_LIMIT)) begin
          count_nxt  = '0;
          emit       = 1'b1;
          status_nxt = nls_pkg::ST_TOO_LONG;
        end else begin
          count_nxt = cnt_inc[nls_pkg::LEN_W-1:0];
          phase_nxt = s.nxt;
        end
      end
      nls_pkg::ACT_ILLEGAL: begin
        emit       = 1'b1;
        status_nxt = nls_pkg::ST_ILLEGAL;
      end
      nls_pkg::ACT_FINISH: begin
        emit = 1'b1;
        if (bad_term) begin
          status_nxt = nls_pkg::ST_ILLEGAL;
        end else begin
          length_nxt = cnt;
        end
      end
      default: begin
        // A character outside any scan leaves everything as it was.
        phase_nxt = ph;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nls_pkg::PH_IDLE;
      count_r <= '0;
      mode_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        mode_r  <= mode_nxt;
      end
      if (fire && emit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (fire && emit) begin
      status_r <= status_nxt;
      length_r <= length_nxt;
    end
  end

  assign out_valid  = out_v_r;
  assign out_status = status_r;
  assign out_length = length_r;

endmodule

// ===== design/nls_checker.sv =====
// Port-level checker for the numeric literal scanner and its bind to the top level.
module nls_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [nls_pkg::STATUS_W-1:0] out_status,
  input logic [nls_pkg::LEN_W-1:0]    out_length
);

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == nls_pkg::ST_OK) || (out_status == nls_pkg::ST_ILLEGAL) ||
                  (out_status == nls_pkg::ST_TOO_LONG))
    else $error("result status is not a defined code");

  // Only a valid literal carries a length.
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != nls_pkg::ST_OK)) |-> (out_length == '0))
    else $error("failed literal carries a nonzero length");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_length)))
    else $error("stalled result changed");

  // Reset empties the result register and opens the input.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind numeric_literal_scanner_core nls_checker u_nls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_status(out_status),
  .out_length(out_length)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the numeric literal scanner core, with its length scoreboard.
module testbench;

  // A string is fed as a queue of characters, the first one carrying the start flag.
  typedef logic [nls_pkg::CHAR_W-1:0] text_t[$];

  // One expected result of a scan: its status and the measured literal length.
  typedef struct packed {
    nls_pkg::status_t            status;
    logic [nls_pkg::LEN_W-1:0]   length;
  } verdict_t;

  // The scoreboard mirrors the scanner's phase, its count of characters taken into the
  // literal and the mode bits latched at the start. Every accepted character steps that
  // mirror. When a scan closes, the expected verdict is queued and later matched in
  // order against what the block reports.
  class literal_scorer;
    nls_pkg::phase_t             scan_phase = nls_pkg::PH_IDLE;
    int unsigned                 taken = 0;
    logic [nls_pkg::MODE_W-1:0]  modes = '0;
    verdict_t                    awaited_lengths[$];
    int unsigned                 mismatches = 0;

    function bit decimal_char(logic [nls_pkg::CHAR_W-1:0] c);
      return (c >= "0") && (c <= "9");
    endfunction

    function bit alpha_char(logic [nls_pkg::CHAR_W-1:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function bit sign_char(logic [nls_pkg::CHAR_W-1:0] c);
      return (c == "+") || (c == "-");
    endfunction

    function bit hex_char(logic [nls_pkg::CHAR_W-1:0] c);
      return decimal_char(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function bit slash_on();
      return modes[nls_pkg::MODE_SLASH_BIT];
    endfunction

    // Closes the scan with a verdict and returns to idle.
    function void report(nls_pkg::status_t st, int unsigned len);
      verdict_t v;
      v.status = st;
      v.length = nls_pkg::LEN_W'(len);
      awaited_lengths.push_back(v);
      scan_phase = nls_pkg::PH_IDLE;
    endfunction

    // Takes a character into the literal, or reports an overlong literal.
    function void advance(nls_pkg::phase_t nxt);
      taken++;
      if (taken > nls_pkg::LEN_LIMIT) begin
        taken = 0;
        report(nls_pkg::ST_TOO_LONG, 0);
      end else begin
        scan_phase = nxt;
      end
    endfunction

    // The character that ends the literal must not look like part of a number.
    function void close_at(logic [nls_pkg::CHAR_W-1:0] c);
      if ((c == ".") || decimal_char(c) || alpha_char(c) || ((c == "/") && slash_on())) begin
        report(nls_pkg::ST_ILLEGAL, 0);
      end else begin
        report(nls_pkg::ST_OK, taken);
      end
    endfunction

    function void body_done(logic [nls_pkg::CHAR_W-1:0] c);
      if (((c == "i") || (c == "I")) && modes[nls_pkg::MODE_IMAG_BIT]) begin
        advance(nls_pkg::PH_SUFFIX);
      end else begin
        close_at(c);
      end
    endfunction

    function void decimal(logic [nls_pkg::CHAR_W-1:0] c);
      if (decimal_char(c)) begin
        advance(nls_pkg::PH_DECINT);
      end else if ((c == "/") && slash_on()) begin
        advance(nls_pkg::PH_FRAC);
      end else if (c == ".") begin
        advance(nls_pkg::PH_POINT);
      end else if ((c == "e") || (c == "E")) begin
        advance(nls_pkg::PH_EXP);
      end else begin
        body_done(c);
      end
    endfunction

    // First character of the number proper; a second sign here is illegal.
    function void mantissa_lead(logic [nls_pkg::CHAR_W-1:0] c);
      if (sign_char(c)) begin
        report(nls_pkg::ST_ILLEGAL, 0);
      end else if (c == "0") begin
        advance(nls_pkg::PH_ZERO);
      end else begin
        decimal(c);
      end
    endfunction

    function void absorb_char(logic [nls_pkg::CHAR_W-1:0] c, logic start,
                              logic [nls_pkg::MODE_W-1:0] mode);
      if (start) begin
        scan_phase = nls_pkg::PH_BEGIN;
        taken = 0;
        modes = mode;
      end
      case (scan_phase)
        nls_pkg::PH_BEGIN: begin
          if (sign_char(c)) advance(nls_pkg::PH_AFTSIGN);
          else mantissa_lead(c);
        end
        nls_pkg::PH_AFTSIGN: mantissa_lead(c);
        nls_pkg::PH_ZERO: begin
          if ((c == "x") || (c == "X")) advance(nls_pkg::PH_HEX);
          else if ((c == "b") || (c == "B")) advance(nls_pkg::PH_BIN);
          else if (decimal_char(c)) begin
            if (c <= "7") advance(nls_pkg::PH_OCT);
            else body_done(c);
          end else decimal(c);
        end
        nls_pkg::PH_HEX: begin
          if (hex_char(c)) advance(nls_pkg::PH_HEX);
          else body_done(c);
        end
        nls_pkg::PH_BIN: begin
          if ((c == "0") || (c == "1")) advance(nls_pkg::PH_BIN);
          else body_done(c);
        end
        nls_pkg::PH_OCT: begin
          if ((c >= "0") && (c <= "7")) advance(nls_pkg::PH_OCT);
          else body_done(c);
        end
        nls_pkg::PH_DECINT: decimal(c);
        nls_pkg::PH_FRAC: begin
          if (decimal_char(c)) advance(nls_pkg::PH_FRAC);
          else body_done(c);
        end
        nls_pkg::PH_POINT: begin
          if (decimal_char(c)) advance(nls_pkg::PH_POINT);
          else if ((c == "e") || (c == "E")) advance(nls_pkg::PH_EXP);
          else body_done(c);
        end
        nls_pkg::PH_EXP: begin
          if (sign_char(c)) advance(nls_pkg::PH_EXPSIGN);
          else if (decimal_char(c)) advance(nls_pkg::PH_EXPDIG);
          else body_done(c);
        end
        nls_pkg::PH_EXPSIGN: begin
          if (sign_char(c)) report(nls_pkg::ST_ILLEGAL, 0);
          else if (decimal_char(c)) advance(nls_pkg::PH_EXPDIG);
          else body_done(c);
        end
        nls_pkg::PH_EXPDIG: begin
          if (decimal_char(c)) advance(nls_pkg::PH_EXPDIG);
          else body_done(c);
        end
        nls_pkg::PH_SUFFIX: close_at(c);
        default: scan_phase = nls_pkg::PH_IDLE;
      endcase
    endfunction

    function void check_verdict(logic [nls_pkg::STATUS_W-1:0] st,
                                logic [nls_pkg::LEN_W-1:0] len);
      verdict_t want;
      if (awaited_lengths.size() == 0) begin
        $error("result with no verdict pending: status %0d length %0d", st, len);
        mismatches++;
        return;
      end
      want = awaited_lengths.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (len !== want.length) begin
        $error("length: expected %0d, actual %0d", want.length, len);
        mismatches++;
      end
    endfunction

    function int unsigned awaiting();
      return awaited_lengths.size();
    endfunction
  endclass

  // The generous bound covers the slowest legal run many times over.
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 120;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [nls_pkg::CHAR_W-1:0]     in_char_in;
  logic                           in_start_req;
  logic [nls_pkg::MODE_W-1:0]     in_mode_flags;
  logic                           out_valid;
  logic                           out_ready;
  logic [nls_pkg::STATUS_W-1:0]   out_status;
  logic [nls_pkg::LEN_W-1:0]      out_length;

  literal_scorer         sb;
  int unsigned           gap_pct = 0;
  int unsigned           stall_pct = 0;
  int unsigned           hold_requests = 0;
  int unsigned           cycle_count = 0;

  numeric_literal_scanner_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_in   (in_char_in),
    .in_start_req (in_start_req),
    .in_mode_flags(in_mode_flags),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_length   (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Handshakes are sampled at the rising edge, where all inputs were set by nonblocking
  // assignments at the edge before, so both monitors see settled values.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.absorb_char(in_char_in, in_start_req, in_mode_flags);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_verdict(out_status, out_length);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls at random. When the stimulus asks for a hold-off, it keeps ready
  // low for a long stretch that it counts itself, so that the block backs up to its input.
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one item after a random number of idle cycles and returns at the edge that
  // accepts it. Valid is left high so that a following item can go out back to back.
  task automatic put_char(input logic [nls_pkg::CHAR_W-1:0] c, input logic start,
                          input logic [nls_pkg::MODE_W-1:0] mode);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_in    <= c;
    in_start_req  <= start;
    in_mode_flags <= mode;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mode bits only matter with the start flag, so the other items carry random ones.
  task automatic send_text(input text_t s, input logic [nls_pkg::MODE_W-1:0] mode);
    for (int i = 0; i < s.size(); i++) begin
      put_char(s[i], i == 0, (i == 0) ? mode : nls_pkg::MODE_W'($urandom_range(3)));
    end
  endtask

  task automatic run_text(input string s, input logic [nls_pkg::MODE_W-1:0] mode);
    text_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_text(q, mode);
  endtask

  // A run of random digits and a space; long runs probe the length limit.
  task automatic send_digit_run(input int unsigned n, input logic [nls_pkg::MODE_W-1:0] mode);
    text_t q;
    repeat (n) q.push_back(nls_pkg::CHAR_W'("0" + $urandom_range(9)));
    q.push_back(" ");
    send_text(q, mode);
  endtask

  // Stops offering until every awaited verdict has come, then lets the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [nls_pkg::CHAR_W-1:0] pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // Builds a mostly well-formed literal with random content and a random terminator.
  // Doubled signs and bad terminators appear now and then to reach the error paths.
  function automatic text_t random_literal(logic slash, logic imag);
    text_t s;
    int unsigned n;
    if ($urandom_range(2) == 0) s.push_back(pick("+-"));
    if ($urandom_range(19) == 0) s.push_back(pick("+-"));
    n = $urandom_range(6);
    case ($urandom_range(5))
      0: begin
        s.push_back("0");
        s.push_back(pick("xX"));
        repeat (n) s.push_back(pick("0123456789abcdefABCDEF"));
      end
      1: begin
        s.push_back("0");
        s.push_back(pick("bB"));
        repeat (n) s.push_back(pick("01"));
      end
      2: begin
        s.push_back("0");
        repeat (n) s.push_back(pick("01234567"));
      end
      default: begin
        repeat (n + 1) s.push_back(pick("0123456789"));
        if (slash && ($urandom_range(2) == 0)) begin
          s.push_back("/");
          repeat ($urandom_range(4)) s.push_back(pick("0123456789"));
        end else begin
          if ($urandom_range(1) == 1) begin
            s.push_back(".");
            repeat ($urandom_range(4)) s.push_back(pick("0123456789"));
          end
          if ($urandom_range(2) == 0) begin
            s.push_back(pick("eE"));
            if ($urandom_range(1) == 1) s.push_back(pick("+-"));
            if ($urandom_range(15) == 0) s.push_back(pick("+-"));
            repeat ($urandom_range(3)) s.push_back(pick("0123456789"));
          end
        end
      end
    endcase
    // The suffix is tried whether or not the imaginary mode allows it.
    if ($urandom_range(imag ? 2 : 6) == 0) s.push_back(pick("iI"));
    case ($urandom_range(9))
      0: s.push_back(pick("./"));
      1: s.push_back(pick("0123456789aZqiX"));
      2: s.push_back(nls_pkg::CHAR_W'($urandom_range(255)));
      3: s.push_back(8'h00);
      default: s.push_back(pick(" ,;)]+-*=\t"));
    endcase
    return s;
  endfunction

  initial begin
    text_t                         lit;
    logic [nls_pkg::MODE_W-1:0]    mode;
    int unsigned                   roll;
    int unsigned                   items_done;
    int unsigned                   gap_tab[4] = '{0, 72, 0, 19};
    int unsigned                   stall_tab[4] = '{0, 0, 72, 19};

    sb = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_char_in    <= '0;
    in_start_req  <= 1'b0;
    in_mode_flags <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: every literal form, the bare forms, the error cases and the
    // terminator checks under each mode.
    run_text("123 ", 2'd0);
    run_text("-0x1fA,", 2'd0);
    run_text("+0b101;", 2'd0);
    run_text("0755 ", 2'd0);
    run_text("089 ", 2'd0);
    run_text("3/4 ", 2'd1);
    run_text("3/4 ", 2'd0);
    run_text("1/2/", 2'd1);
    run_text("1.5e-7 ", 2'd0);
    run_text("2.5E+3i ", 2'd2);
    run_text("7i ", 2'd0);
    run_text("4ix", 2'd2);
    run_text("1/2i)", 2'd3);
    run_text("+-1", 2'd0);
    run_text("1e+-2", 2'd0);
    run_text(" ", 2'd0);
    run_text("0x;", 2'd0);
    run_text("0B2", 2'd0);
    run_text("- ", 2'd0);
    run_text(". ", 2'd0);
    run_text("e5 ", 2'd0);
    run_text("1.2.3", 2'd0);
    run_text("0xFg", 2'd0);
    // A NUL as the very first character gives an empty but valid literal.
    put_char(8'h00, 1'b1, 2'd3);
    // The top character code ends a literal, and a stray character after the result
    // arrives while the scanner is idle and must be ignored.
    put_char("5", 1'b1, 2'd0);
    put_char(8'hFF, 1'b0, 2'd0);
    put_char("9", 1'b0, 2'd0);
    // A start in the middle of a scan drops the open one without a result.
    run_text("123", 2'd0);
    run_text("9 ", 2'd0);
    // Longest legal literal, then one character too many.
    send_digit_run(nls_pkg::LEN_LIMIT, 2'd0);
    send_digit_run(nls_pkg::LEN_LIMIT + 1, 2'd1);
    wait_drained();

    // Long receiver hold-off while the sender keeps pushing short literals, so the result
    // and input registers fill and in_ready drops. Then a full drain before going on.
    hold_requests = hold_requests + 1;
    repeat (20) run_text("7,", 2'd0);
    wait_drained();

    // Random part in four idling phases: none, sender gaps, receiver stalls, both.
    items_done = 0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = gap_tab[ph];
      stall_pct = stall_tab[ph];
      while (items_done < (ph + 1) * 50) begin
        mode = nls_pkg::MODE_W'($urandom_range(3));
        roll = $urandom_range(99);
        if (roll < 80) begin
          lit = random_literal(mode[nls_pkg::MODE_SLASH_BIT], mode[nls_pkg::MODE_IMAG_BIT]);
          // Cutting the terminator leaves the scan open for the next start to drop.
          if (($urandom_range(11) == 0) && (lit.size() > 1)) void'(lit.pop_back());
          send_text(lit, mode);
          items_done += lit.size();
        end else begin
          lit.delete();
          repeat ($urandom_range(1, 8)) lit.push_back(nls_pkg::CHAR_W'($urandom_range(255)));
          send_text(lit, mode);
          items_done += lit.size();
        end
        // Occasional stray characters without a start flag.
        if ($urandom_range(7) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            put_char(nls_pkg::CHAR_W'($urandom_range(255)), 1'b0,
                     nls_pkg::MODE_W'($urandom_range(3)));
            items_done++;
          end
        end
      end
    end

    gap_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaiting() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
